// ===== design/hdpc_pkg.sv =====
// hdpc_pkg: shared types, constants and the modular add for the path counter
// no dependencies; used by every other file of the block but hdpc_ram
`default_nettype none

package hdpc_pkg;

    // fixed field widths
    localparam int NODE_COUNT_W  = 11;
    localparam int PATH_LENGTH_W = 6;
    localparam int PATH_TOTAL_W  = 17;

    // modulus and register reset value
    localparam logic [PATH_TOTAL_W-1:0] PATH_MOD         = 17'd100003;
    localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_READ,
        S_WRITE,
        S_SUM,
        S_SUM_END
    } t_state;

    // accumulator control from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctrl;

    // sum of two residues, reduced once
    function automatic logic [PATH_TOTAL_W-1:0] add_mod(
        input logic [PATH_TOTAL_W-1:0] a,
        input logic [PATH_TOTAL_W-1:0] b
    );
        logic [PATH_TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PATH_MOD}) begin
            s = s - {1'b0, PATH_MOD};
        end
        return s[PATH_TOTAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/hdpc_ram.sv =====
// hdpc_ram: generic single-clock ram, one write port, one registered read port
// no dependencies
`default_nettype none

module hdpc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/hdpc_accum.sv =====
// hdpc_accum: shared modular accumulator, adds one ram word per cycle while add is set
// depends on hdpc_pkg
`default_nettype none

module hdpc_accum (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire hdpc_pkg::t_acc_ctrl                 i_ctrl,
    input  wire logic [hdpc_pkg::PATH_TOTAL_W-1:0]   i_operand,
    output logic      [hdpc_pkg::PATH_TOTAL_W-1:0]   o_sum
);

    logic [hdpc_pkg::PATH_TOTAL_W-1:0] r_acc;
    logic [hdpc_pkg::PATH_TOTAL_W-1:0] n_acc;

    // value after this cycle's add, also seen by the sequencer
    always_comb begin
        if (i_ctrl.add) begin
            o_sum = hdpc_pkg::add_mod(r_acc, i_operand);
        end else begin
            o_sum = r_acc;
        end
    end

    // clear wins over add
    always_comb begin
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else begin
            n_acc = o_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

endmodule

`default_nettype wire

// ===== design/hdpc_ctrl.sv =====
// hdpc_ctrl: sequencer for fill, update rounds and final sum over the count ram
// depends on hdpc_pkg; drives hdpc_ram and hdpc_accum through the top level
`default_nettype none

module hdpc_ctrl #(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_LENGTH = 63
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    input  wire logic [hdpc_pkg::PATH_LENGTH_W-1:0]   i_path_length,
    input  wire logic [hdpc_pkg::NODE_COUNT_W-1:0]    i_node_count,
    input  wire logic [hdpc_pkg::PATH_TOTAL_W-1:0]    i_sum,
    output logic                                      busy,
    output logic                                      o_we,
    output logic      [$clog2(MAX_NODES)-1:0]         o_waddr,
    output logic      [hdpc_pkg::PATH_TOTAL_W-1:0]    o_wdata,
    output logic                                      o_re,
    output logic      [$clog2(MAX_NODES)-1:0]         o_raddr,
    output hdpc_pkg::t_acc_ctrl                       o_acc,
    output logic                                      o_done,
    output logic      [hdpc_pkg::PATH_TOTAL_W-1:0]    o_path_total
);

    localparam int AW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int KW  = $clog2(MAX_LENGTH + 1);
    localparam int BW  = AW;
    localparam int BIW = (BW > 1) ? $clog2(BW) : 1;

    hdpc_pkg::t_state r_state, n_state;
    logic [AW-1:0]  r_node, n_node;
    logic [BIW-1:0] r_bit, n_bit;
    logic [KW-1:0]  r_round, n_round;
    logic [CW-1:0]  r_n, n_n;
    logic [KW-1:0]  r_k, n_k;
    logic           r_pend, n_pend;
    logic           r_done, n_done;
    logic [hdpc_pkg::PATH_TOTAL_W-1:0] r_total, n_total;

    logic [CW-1:0] n_sat;
    logic [KW-1:0] k_sat;
    logic [AW-1:0] bit_mask;
    logic [AW-1:0] nbr;
    logic          nbr_ok;
    logic          node_last;
    logic          bit_last;
    logic          round_last;

    // saturate the query parameters
    always_comb begin
        if (32'(i_node_count) > 32'(MAX_NODES)) begin
            n_sat = CW'(MAX_NODES);
        end else begin
            n_sat = CW'(i_node_count);
        end
        if (32'(i_path_length) > 32'(MAX_LENGTH)) begin
            k_sat = KW'(MAX_LENGTH);
        end else begin
            k_sat = KW'(i_path_length);
        end
    end

    // neighbor address for the current bit
    assign bit_mask   = AW'(1) << r_bit;
    assign nbr        = r_node | bit_mask;
    assign nbr_ok     = ((r_node & bit_mask) == '0) && (CW'(nbr) < r_n);
    assign node_last  = (CW'(r_node) == (r_n - CW'(1)));
    assign bit_last   = (r_bit == BIW'(BW - 1));
    assign round_last = (r_round == (r_k - KW'(1)));

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hdpc_pkg::S_IDLE;
            r_node  <= '0;
            r_bit   <= '0;
            r_round <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_node  <= n_node;
            r_bit   <= n_bit;
            r_round <= n_round;
            r_n     <= n_n;
            r_k     <= n_k;
            r_pend  <= n_pend;
            r_done  <= n_done;
            r_total <= n_total;
        end
    end

    // next state and ram / accumulator control
    always_comb begin
        n_state   = r_state;
        n_node    = r_node;
        n_bit     = r_bit;
        n_round   = r_round;
        n_n       = r_n;
        n_k       = r_k;
        n_pend    = 1'b0;
        n_done    = 1'b0;
        n_total   = r_total;
        o_we      = 1'b0;
        o_waddr   = r_node;
        o_wdata   = i_sum;
        o_re      = 1'b0;
        o_raddr   = nbr;
        o_acc.add   = r_pend;
        o_acc.clear = 1'b0;
        case (r_state)
            hdpc_pkg::S_IDLE: begin
                if (start) begin
                    n_n     = n_sat;
                    n_k     = k_sat;
                    n_node  = '0;
                    n_bit   = '0;
                    n_round = '0;
                    if ((n_sat == '0) || (k_sat == '0)) begin
                        n_done  = 1'b1;
                        n_total = '0;
                    end else begin
                        n_state = hdpc_pkg::S_FILL;
                    end
                end
            end
            // every node starts at one
            hdpc_pkg::S_FILL: begin
                o_we    = 1'b1;
                o_wdata = hdpc_pkg::PATH_TOTAL_W'(1);
                if (node_last) begin
                    n_node  = '0;
                    n_state = hdpc_pkg::S_READ;
                end else begin
                    n_node = r_node + AW'(1);
                end
            end
            // at most one neighbor read per cycle
            hdpc_pkg::S_READ: begin
                o_re        = nbr_ok;
                n_pend      = nbr_ok;
                o_acc.clear = (r_bit == '0);
                if (bit_last) begin
                    n_bit   = '0;
                    n_state = hdpc_pkg::S_WRITE;
                end else begin
                    n_bit = r_bit + BIW'(1);
                end
            end
            // last read lands, node count written back in place
            hdpc_pkg::S_WRITE: begin
                o_we = 1'b1;
                if (node_last) begin
                    n_node = '0;
                    if (round_last) begin
                        n_state = hdpc_pkg::S_SUM;
                    end else begin
                        n_round = r_round + KW'(1);
                        n_state = hdpc_pkg::S_READ;
                    end
                end else begin
                    n_node  = r_node + AW'(1);
                    n_state = hdpc_pkg::S_READ;
                end
            end
            // total over all nodes
            hdpc_pkg::S_SUM: begin
                o_re        = 1'b1;
                o_raddr     = r_node;
                n_pend      = 1'b1;
                o_acc.clear = (r_node == '0);
                if (node_last) begin
                    n_state = hdpc_pkg::S_SUM_END;
                end else begin
                    n_node = r_node + AW'(1);
                end
            end
            hdpc_pkg::S_SUM_END: begin
                n_done  = 1'b1;
                n_total = i_sum;
                n_state = hdpc_pkg::S_IDLE;
            end
            default: begin
                n_state = hdpc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != hdpc_pkg::S_IDLE);
    assign o_done       = r_done;
    assign o_path_total = r_total;

endmodule

`default_nettype wire

// ===== design/hypercube_dag_path_counter.sv =====
// hypercube_dag_path_counter: top level, node count register and unit wiring
// depends on hdpc_pkg, hdpc_ram, hdpc_accum, hdpc_ctrl
//
//  channel   ports                               transfer
//  config    i_node_count_we, i_node_count       edge with i_node_count_we high
//  input     start, busy, i_path_length          edge with start high, busy low
//  result    o_done, o_path_total                edge ending the o_done cycle
//
// A query of length k over n nodes fills the count ram for all n nodes, then
// runs k update rounds that read each node's larger neighbors and write its count
// back, then sums all n counts and registers the result; the single ram read port
// serves one neighbor per cycle. A zero length or zero node count answers with
// o_done in the next cycle. Reset is synchronous; the count ram needs no clearing
// since every query refills it. The receiver cannot stall the result.
`default_nettype none

module hypercube_dag_path_counter #(
    parameter int MAX_NODES  = 1024,
    parameter int MAX_LENGTH = 63
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_node_count_we,
    input  wire logic [hdpc_pkg::NODE_COUNT_W-1:0]    i_node_count,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [hdpc_pkg::PATH_LENGTH_W-1:0]   i_path_length,
    output logic                                      o_done,
    output logic      [hdpc_pkg::PATH_TOTAL_W-1:0]    o_path_total
);

    localparam int AW = $clog2(MAX_NODES);

    logic [hdpc_pkg::NODE_COUNT_W-1:0] r_node_count;
    logic [hdpc_pkg::PATH_TOTAL_W-1:0] sum;
    logic [hdpc_pkg::PATH_TOTAL_W-1:0] rdata;
    logic [hdpc_pkg::PATH_TOTAL_W-1:0] wdata;
    logic [AW-1:0]                     waddr;
    logic [AW-1:0]                     raddr;
    logic                              we;
    logic                              re;
    hdpc_pkg::t_acc_ctrl               acc_ctrl;

    // node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= hdpc_pkg::NODE_COUNT_RESET;
        end else if (i_node_count_we) begin
            r_node_count <= i_node_count;
        end
    end

    // sequencer
    hdpc_ctrl #(
        .MAX_NODES  (MAX_NODES),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_path_length (i_path_length),
        .i_node_count  (r_node_count),
        .i_sum         (sum),
        .busy          (busy),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_re          (re),
        .o_raddr       (raddr),
        .o_acc         (acc_ctrl),
        .o_done        (o_done),
        .o_path_total  (o_path_total)
    );

    // per-node count store
    hdpc_ram #(
        .WIDTH (hdpc_pkg::PATH_TOTAL_W),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // shared modular adder
    hdpc_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (acc_ctrl),
        .i_operand (rdata),
        .o_sum     (sum)
    );

endmodule

`default_nettype wire

// ===== dv/hypercube_dag_path_counter_test.sv =====
// hypercube_dag_path_counter_test: self-checking bench for the hypercube path counter
// predicts each path total in the bench and checks it against every o_done transfer
// depends on hdpc_pkg and hypercube_dag_path_counter
`default_nettype none

module hypercube_dag_path_counter_test;

    localparam int    NODE_LIMIT     = 1024;
    localparam int    LENGTH_LIMIT   = 63;
    localparam int    ADDR_BITS      = 11;
    localparam int    CLK_HALF       = 6;
    localparam int    RESET_CYCLES   = 7;
    localparam int    SETTLE_CYCLES  = 20;
    localparam int    REPORT_LIMIT   = 10;
    localparam longint TIMEOUT_CYCLES = 12_000_000;

    // clock, reset and block inputs, all known from time zero
    logic                                 i_clk           = 1'b0;
    logic                                 i_rst_n         = 1'b0;
    logic                                 i_node_count_we = 1'b0;
    logic [hdpc_pkg::NODE_COUNT_W-1:0]    i_node_count    = '0;
    logic                                 start           = 1'b0;
    logic [hdpc_pkg::PATH_LENGTH_W-1:0]   i_path_length   = '0;
    logic                                 busy;
    logic                                 o_done;
    logic [hdpc_pkg::PATH_TOTAL_W-1:0]    o_path_total;

    // bench copy of the node count register and the per-node path store
    logic [hdpc_pkg::NODE_COUNT_W-1:0]    node_count_cfg;
    int unsigned                          paths_from [NODE_LIMIT];

    // path totals waiting for their o_done transfer
    logic [hdpc_pkg::PATH_TOTAL_W-1:0]    totals_due [$];
    int                                   error_count = 0;

    hypercube_dag_path_counter #(
        .MAX_NODES  (NODE_LIMIT),
        .MAX_LENGTH (LENGTH_LIMIT)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_node_count_we (i_node_count_we),
        .i_node_count    (i_node_count),
        .start           (start),
        .busy            (busy),
        .i_path_length   (i_path_length),
        .o_done          (o_done),
        .o_path_total    (o_path_total)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // residue sum reduced once
    function automatic int unsigned add_residue(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s >= hdpc_pkg::PATH_MOD) ? s - hdpc_pkg::PATH_MOD : s;
    endfunction

    // paths of exactly len edges, counted round by round in ascending node order
    function automatic logic [hdpc_pkg::PATH_TOTAL_W-1:0] count_paths(
        input logic [hdpc_pkg::NODE_COUNT_W-1:0]  raw_nodes,
        input logic [hdpc_pkg::PATH_LENGTH_W-1:0] len
    );
        int unsigned nodes;
        int unsigned acc;
        int unsigned total;
        int unsigned nb;
        int          i;
        int          r;
        int          b;
        nodes = (raw_nodes > NODE_LIMIT) ? NODE_LIMIT : raw_nodes;
        total = 0;
        if (len != 0 && nodes != 0) begin
            for (i = 0; i < nodes; i++) begin
                paths_from[i] = 1;
            end
            for (r = 0; r < len; r++) begin
                for (i = 0; i < nodes; i++) begin
                    acc = 0;
                    // larger neighbors still hold last round's counts
                    for (b = 0; b < ADDR_BITS && (1 << b) < nodes; b++) begin
                        if ((i & (1 << b)) == 0) begin
                            nb = i | (1 << b);
                            if (nb < nodes) begin
                                acc = add_residue(acc, paths_from[nb]);
                            end
                        end
                    end
                    paths_from[i] = acc;
                end
            end
            for (i = 0; i < nodes; i++) begin
                total = add_residue(total, paths_from[i]);
            end
        end
        return total[hdpc_pkg::PATH_TOTAL_W-1:0];
    endfunction

    // result checker, one transfer per o_done cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (totals_due.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("unexpected result: path_total=%0d", o_path_total);
                end
            end else begin
                if (o_path_total !== totals_due[0]) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("path_total mismatch: expected %0d, got %0d",
                                 totals_due[0], o_path_total);
                    end
                end
                void'(totals_due.pop_front());
            end
        end
    end

    // one command transfer; start stays high so the next item can follow at once
    task automatic send_length(input logic [hdpc_pkg::PATH_LENGTH_W-1:0] len);
        start         <= 1'b1;
        i_path_length <= len;
        do begin
            @(posedge i_clk);
        end while (busy);
        totals_due = {totals_due, count_paths(node_count_cfg, len)};
    endtask

    // idle the command side for the given number of cycles
    task automatic idle_cycles(input int cycles);
        if (cycles > 0) begin
            start         <= 1'b0;
            i_path_length <= 6'($urandom);
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 80);
    endfunction

    // hold off commands until every expected total has come back
    task automatic drain_results();
        start <= 1'b0;
        while (totals_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // node count write, only with the block idle
    task automatic set_node_count(input logic [hdpc_pkg::NODE_COUNT_W-1:0] count);
        drain_results();
        i_node_count_we <= 1'b1;
        i_node_count    <= count;
        @(posedge i_clk);
        i_node_count_we <= 1'b0;
        node_count_cfg   = count;
    endtask

    // reset value of the node count is in force without any write
    task automatic test_reset_count();
        send_length(6'd0);
        send_length(6'd1);
    endtask

    // zero nodes answer zero whatever the length
    task automatic test_empty_graph();
        set_node_count(11'd0);
        send_length(6'd0);
        send_length(6'd63);
        idle_cycles(3);
        send_length(6'd7);
    endtask

    // node counts above the limit saturate to a full cube
    task automatic test_saturated_count();
        set_node_count(11'd2047);
        send_length(6'd1);
        set_node_count(11'd1025);
        send_length(6'd2);
    endtask

    // one and two nodes, including the longest length
    task automatic test_tiny_graphs();
        set_node_count(11'd1);
        send_length(6'd0);
        send_length(6'd1);
        send_length(6'd63);
        set_node_count(11'd2);
        send_length(6'd1);
        idle_cycles(pick_gap());
        send_length(6'd63);
    endtask

    // complete and ragged cubes, back to back
    task automatic test_cube_shapes();
        set_node_count(11'd16);
        send_length(6'd4);
        send_length(6'd63);
        send_length(6'd1);
        set_node_count(11'd33);
        send_length(6'd3);
        send_length(6'd63);
    endtask

    // large node counts at short lengths
    task automatic test_wide_count();
        set_node_count(11'd1023);
        send_length(6'd2);
        set_node_count(11'd1024);
        send_length(6'd2);
    endtask

    // random phases: small graphs take any length, large ones only short lengths
    task automatic test_random_phases();
        int          phase;
        int          item;
        int          pick;
        int          max_len;
        bit          steady;
        logic [10:0] count;
        logic [5:0]  len;
        for (phase = 0; phase < 10; phase++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                count   = 11'($urandom_range(0, 16));
                max_len = LENGTH_LIMIT;
            end else if (pick < 92) begin
                count   = 11'($urandom_range(17, 64));
                max_len = 15;
            end else begin
                count   = 11'($urandom_range(1023, 2047));
                max_len = 2;
            end
            set_node_count(count);
            steady = ($urandom_range(0, 3) == 0);
            for (item = 0; item < 10; item++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    len = 6'd0;
                end else if (pick == 1) begin
                    len = 6'(max_len);
                end else begin
                    len = 6'($urandom_range(0, max_len));
                end
                send_length(len);
                if (!steady) begin
                    idle_cycles(pick_gap());
                end
            end
        end
    endtask

    // main sequence
    initial begin
        node_count_cfg = hdpc_pkg::NODE_COUNT_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_count();
        test_empty_graph();
        test_saturated_count();
        test_tiny_graphs();
        test_cube_shapes();
        test_wide_count();
        test_random_phases();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && totals_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run time limit
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
design/hdpc_pkg.sv
design/hdpc_ram.sv
design/hdpc_accum.sv
design/hdpc_ctrl.sv
design/hypercube_dag_path_counter.sv
dv/hypercube_dag_path_counter_test.sv
